// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands; ASSERT_OFF compiles them away.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== src/pts_pkg.sv =====
// ----------------------------------------------------------------------------
// pts_pkg
// Types, constants and helper functions for the phasor to time sample block.
// ----------------------------------------------------------------------------
`default_nettype none

package pts_pkg;

  // configuration register indexes
  localparam logic REG_STEP_COUNT = 1'b0;
  localparam logic REG_PHASE_STEP = 1'b1;

  localparam int STEP_COUNT_W = 7;
  localparam int PHASE_W      = 16;
  localparam int CFG_DATA_W   = 16;
  localparam int STEP_IDX_W   = 6;

  // CORDIC: Q2.30 datapath, gain-compensated start value
  localparam int                 CORDIC_ITERS = 15;
  localparam int                 CORDIC_W     = 33;
  localparam logic signed [32:0] CORDIC_X0    = 33'sd652032874;

  // 17-bit so that a negated -32768 still fits
  typedef struct packed {
    logic signed [16:0] cos_v;
    logic signed [16:0] sin_v;
  } trig_entry_t;

  // arctangent of 2^-i in units of a quarter turn / 16384
  function automatic logic [13:0] atan_unit(input logic [3:0] i);
    logic [13:0] a;
    case (i)
      4'd0:    a = 14'd8192;
      4'd1:    a = 14'd4836;
      4'd2:    a = 14'd2555;
      4'd3:    a = 14'd1297;
      4'd4:    a = 14'd651;
      4'd5:    a = 14'd326;
      4'd6:    a = 14'd163;
      4'd7:    a = 14'd81;
      4'd8:    a = 14'd41;
      4'd9:    a = 14'd20;
      4'd10:   a = 14'd10;
      4'd11:   a = 14'd5;
      4'd12:   a = 14'd3;
      default: a = 14'd1;
    endcase
    return a;
  endfunction

  // Q2.30 -> Q1.15, round half up, clamp to the 16-bit range
  function automatic logic signed [16:0] q15_round(input logic signed [32:0] v);
    logic signed [32:0] t;
    logic signed [17:0] r;
    logic signed [16:0] res;
    t = v + 33'sd16384;
    r = $signed(t[32:15]);
    if (r > 18'sd32767)
      res = 17'sd32767;
    else if (r < -18'sd32768)
      res = -17'sd32768;
    else
      res = r[16:0];
    return res;
  endfunction

  // ceil(sqrt(2^(2*dw-1))), elaboration only
  function automatic logic [63:0] sample_limit(input int dw);
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] t;
    n = 64'd1 << (2 * dw - 1);
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= n)
        r = t;
    end
    if (r * r < n)
      r = r + 64'd1;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/phasor_to_time_samples.sv =====
// ----------------------------------------------------------------------------
// phasor_to_time_samples
// Expands one complex phasor into a run of time samples re*cos - im*sin.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one beat carries a phasor (real, imaginary). Each
//   beat produces a run of N = clamp(step_count, 1, MAX_STEPS) output beats,
//   sample k at phase k*phase_step (16-bit turn fraction), out_last on k=N-1.
//   Output channel (out_*): sample, step index k, last flag.
//   Config port: cfg_wr_en/cfg_index/cfg_data, written while the block idles.
// Timing:
//   A table of N cos/sin pairs sits in one synchronous RAM, built by an
//   iterative CORDIC that loads, iterates and writes one entry after the
//   other. The build runs after reset and again after every config write;
//   in_stall stays high until it is done.
//   Once built, the RAM read port streams one sample per cycle unless
//   out_stall holds it; each input beat starts a run of N samples.
//   The next phasor is accepted in the cycle its predecessor issues its
//   last RAM read, so runs follow without a gap.
// Backpressure:
//   out_stall with out_valid high freezes the whole read/multiply/output pipeline
//   (and the RAM output register); nothing is lost or repeated; in_stall rises during a run.
// ----------------------------------------------------------------------------
`default_nettype none

module phasor_to_time_samples #(
  parameter int MAX_STEPS  = 64,
  parameter int DATA_WIDTH = 16
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // config port
  input  wire                                  cfg_wr_en,
  input  wire logic                            cfg_index,
  input  wire logic [pts_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input channel
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire logic signed [DATA_WIDTH-1:0]    in_real_part,
  input  wire logic signed [DATA_WIDTH-1:0]    in_imag_part,
  // output channel
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic signed [DATA_WIDTH:0]           out_sample,
  output logic [pts_pkg::STEP_IDX_W-1:0]       out_step_index,
  output logic                                 out_last
);

  localparam int AW  = $clog2(MAX_STEPS);
  localparam int DW  = DATA_WIDTH;
  localparam int PW  = DW + 17;   // product width
  localparam int SW  = DW + 18;   // difference width
  localparam int RW  = SW - 15;   // after the Q15 shift
  localparam logic signed [RW-1:0] LIM = RW'(pts_pkg::sample_limit(DW));

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [pts_pkg::STEP_COUNT_W-1:0] step_count_r;
  logic [pts_pkg::PHASE_W-1:0]      phase_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_count_r <= 7'd20;
      phase_step_r <= 16'd3277;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        pts_pkg::REG_STEP_COUNT: step_count_r <= cfg_data[pts_pkg::STEP_COUNT_W-1:0];
        pts_pkg::REG_PHASE_STEP: phase_step_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // index of the last sample in a run: zero count acts as one, cap at MAX_STEPS
  logic [AW-1:0] last_idx;

  always_comb begin
    if (step_count_r == '0)
      last_idx = '0;
    else if (32'(step_count_r) >= MAX_STEPS)
      last_idx = AW'(MAX_STEPS - 1);
    else
      last_idx = AW'(step_count_r - 7'd1);
  end

  // --------------------------------------------------------------------------
  // Table build: one CORDIC iteration per cycle, one RAM write per entry
  // --------------------------------------------------------------------------
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ITER,
    ST_WRITE,
    ST_READY
  } build_state_t;

  build_state_t              state_r;
  logic [AW-1:0]             fill_k_r;
  logic [pts_pkg::PHASE_W-1:0] phase_r;
  logic [1:0]                quad_r;
  logic [3:0]                iter_r;
  logic signed [pts_pkg::CORDIC_W-1:0] x_r;
  logic signed [pts_pkg::CORDIC_W-1:0] y_r;
  logic signed [15:0]        z_r;

  logic signed [pts_pkg::CORDIC_W-1:0] dx;
  logic signed [pts_pkg::CORDIC_W-1:0] dy;
  logic signed [15:0]        da;

  assign dx = y_r >>> iter_r;
  assign dy = x_r >>> iter_r;
  assign da = $signed({2'b00, pts_pkg::atan_unit(iter_r)});

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr_en) begin
      // any register change invalidates the table
      state_r  <= ST_LOAD;
      fill_k_r <= '0;
      phase_r  <= '0;
    end else begin
      case (state_r)
        ST_LOAD: begin
          x_r     <= pts_pkg::CORDIC_X0;
          y_r     <= '0;
          z_r     <= $signed({2'b00, phase_r[13:0]});
          quad_r  <= phase_r[15:14];
          iter_r  <= '0;
          state_r <= ST_ITER;
        end
        ST_ITER: begin
          if (!z_r[15]) begin
            x_r <= x_r - dx;
            y_r <= y_r + dy;
            z_r <= z_r - da;
          end else begin
            x_r <= x_r + dx;
            y_r <= y_r - dy;
            z_r <= z_r + da;
          end
          iter_r <= iter_r + 4'd1;
          if (iter_r == 4'(pts_pkg::CORDIC_ITERS - 1))
            state_r <= ST_WRITE;
        end
        ST_WRITE: begin
          if (fill_k_r == last_idx) begin
            state_r <= ST_READY;
          end else begin
            fill_k_r <= fill_k_r + AW'(1);
            phase_r  <= phase_r + phase_step_r;
            state_r  <= ST_LOAD;
          end
        end
        ST_READY: ;
        default: state_r <= ST_LOAD;
      endcase
    end
  end

  logic ready;
  logic wr_en;
  pts_pkg::trig_entry_t wr_entry;
  logic signed [16:0] c_q;
  logic signed [16:0] s_q;

  assign ready = (state_r == ST_READY);
  assign wr_en = (state_r == ST_WRITE);
  assign c_q   = pts_pkg::q15_round(x_r);
  assign s_q   = pts_pkg::q15_round(y_r);

  // fold the first-quadrant pair out to the full turn
  always_comb begin
    case (quad_r)
      2'd0: begin
        wr_entry.cos_v = c_q;
        wr_entry.sin_v = s_q;
      end
      2'd1: begin
        wr_entry.cos_v = -s_q;
        wr_entry.sin_v = c_q;
      end
      2'd2: begin
        wr_entry.cos_v = -c_q;
        wr_entry.sin_v = -s_q;
      end
      default: begin
        wr_entry.cos_v = s_q;
        wr_entry.sin_v = -c_q;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Run sequencer and sample pipeline
  // Writes happen only while building, reads only when ready, so the two
  // never touch the same entry in one cycle.
  // --------------------------------------------------------------------------
  logic ce;            // pipeline advance
  logic rd_en;
  logic issue_last;
  logic in_acc;

  logic                  run_r;
  logic [AW-1:0]         k_r;
  logic signed [DW-1:0]  item_re_r;
  logic signed [DW-1:0]  item_im_r;

  assign ce         = !out_valid || !out_stall;
  assign rd_en      = ce && run_r && ready;
  assign issue_last = (k_r == last_idx);
  assign in_stall   = !(ready && (!run_r || (rd_en && issue_last)));
  assign in_acc     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      k_r   <= '0;
    end else if (in_acc) begin
      run_r     <= 1'b1;
      k_r       <= '0;
      item_re_r <= in_real_part;
      item_im_r <= in_imag_part;
    end else if (rd_en) begin
      if (issue_last)
        run_r <= 1'b0;
      else
        k_r <= k_r + AW'(1);
    end
  end

  // table RAM
  pts_pkg::trig_entry_t mem [MAX_STEPS];
  pts_pkg::trig_entry_t rd_entry_r;

  always_ff @(posedge clk) begin
    if (wr_en)
      mem[fill_k_r] <= wr_entry;
    if (rd_en)
      rd_entry_r <= mem[k_r];
  end

  // stage 1: RAM data out, phasor carried alongside
  logic                 s1_v_r;
  logic [AW-1:0]        s1_k_r;
  logic                 s1_last_r;
  logic signed [DW-1:0] s1_re_r;
  logic signed [DW-1:0] s1_im_r;
  // stage 2: products
  logic                 s2_v_r;
  logic [AW-1:0]        s2_k_r;
  logic                 s2_last_r;
  logic signed [PW-1:0] p_re_r;
  logic signed [PW-1:0] p_im_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (ce) begin
      s1_v_r <= rd_en;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s1_k_r    <= k_r;
      s1_last_r <= issue_last;
      s1_re_r   <= item_re_r;
      s1_im_r   <= item_im_r;
      s2_k_r    <= s1_k_r;
      s2_last_r <= s1_last_r;
      p_re_r    <= PW'(s1_re_r) * PW'(rd_entry_r.cos_v);
      p_im_r    <= PW'(s1_im_r) * PW'(rd_entry_r.sin_v);
    end
  end

  // stage 3: difference, round, saturate to +-LIM
  logic signed [SW-1:0] acc_sum;
  logic signed [RW-1:0] acc_sh;
  logic signed [RW-1:0] acc_sat;
  logic [31:0]          k_wide;

  assign acc_sum = $signed({p_re_r[PW-1], p_re_r}) - $signed({p_im_r[PW-1], p_im_r})
                 + $signed(SW'(16384));
  assign acc_sh  = $signed(acc_sum[SW-1:15]);
  assign k_wide  = 32'(s2_k_r);

  always_comb begin
    if (acc_sh > LIM)
      acc_sat = LIM;
    else if (acc_sh < -LIM)
      acc_sat = -LIM;
    else
      acc_sat = acc_sh;
  end

  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n)
      out_valid_r <= 1'b0;
    else if (ce)
      out_valid_r <= s2_v_r;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_sample     <= acc_sat[DW:0];
      out_step_index <= k_wide[pts_pkg::STEP_IDX_W-1:0];
      out_last       <= s2_last_r;
    end
  end

  assign out_valid = out_valid_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`include "assert_macros.svh"

  // no phasor is taken before the table is complete
  `ASSERT_IMP(a_acc_needs_table, clk, rst_n, in_acc, ready)
  // table write and pipeline read never share a cycle
  `ASSERT_IMP(a_rw_exclusive, clk, rst_n, wr_en, !rd_en)
  // issuing the last read ends the run unless a new phasor follows
  `ASSERT_NXT(a_run_ends, clk, rst_n, rd_en && issue_last && !in_acc, !run_r)

endmodule

`default_nettype wire
